FILE: hdl/mmdu_pkg.sv
package mmdu_pkg;

	// Arithmetic width of HI, LO and the shared adder
	localparam int WORD_BITS = 32;
	localparam int STEP_BITS = $clog2(WORD_BITS);
	localparam logic [STEP_BITS-1:0] STEP_LAST = STEP_BITS'(WORD_BITS - 1);

	// Beat layout
	localparam int CMD_BITS     = 3;
	localparam int DATA_BITS    = 32;
	localparam int A_LSB        = CMD_BITS;
	localparam int B_LSB        = CMD_BITS + DATA_BITS;
	localparam int S_TDATA_BITS = 72;
	localparam int M_TDATA_BITS = 32;

	localparam logic [CMD_BITS-1:0] CMD_MULU  = 3'd0;
	localparam logic [CMD_BITS-1:0] CMD_DIVU  = 3'd1;
	localparam logic [CMD_BITS-1:0] CMD_DIVS  = 3'd2;
	localparam logic [CMD_BITS-1:0] CMD_RD_HI = 3'd3;
	localparam logic [CMD_BITS-1:0] CMD_RD_LO = 3'd4;
	localparam logic [CMD_BITS-1:0] CMD_WR_HI = 3'd5;
	localparam logic [CMD_BITS-1:0] CMD_WR_LO = 3'd6;

	typedef enum logic [1:0] {
		OP_MULU,
		OP_DIVU,
		OP_DIVS
	} mdu_op_t;

	typedef struct packed {
		logic    start;
		mdu_op_t op;
	} core_req_t;

	typedef struct packed {
		logic busy;
		logic done;
	} core_rsp_t;

endpackage

FILE: hdl/mmdu_core.sv
module mmdu_core import mmdu_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  core_req_t            req,
	input  logic [WORD_BITS-1:0] opa,
	input  logic [WORD_BITS-1:0] opb,
	output core_rsp_t            rsp,
	output logic [WORD_BITS-1:0] hi,
	output logic [WORD_BITS-1:0] lo
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_NEGA = 3'd1;
	localparam logic [2:0] ST_NEGB = 3'd2;
	localparam logic [2:0] ST_RUN  = 3'd3;
	localparam logic [2:0] ST_FIXQ = 3'd4;
	localparam logic [2:0] ST_FIXR = 3'd5;

	logic [2:0]           state_q;
	logic [STEP_BITS-1:0] count_q;
	mdu_op_t              op_q;
	logic                 a_neg_q;
	logic                 b_neg_q;
	logic                 done_q;

	// acc_q: product high half or partial remainder; lo_q: multiplier/product low or quotient
	logic [WORD_BITS-1:0] acc_q;
	logic [WORD_BITS-1:0] lo_q;
	logic [WORD_BITS-1:0] opnd_q;

	logic [WORD_BITS:0]   add_x;
	logic [WORD_BITS:0]   add_y;
	logic                 add_sub;
	logic [WORD_BITS+1:0] add_sum;
	logic                 no_borrow;

	// Shared adder: negation, multiply accumulate and trial subtract all pass through here
	always_comb begin
		add_x   = '0;
		add_y   = '0;
		add_sub = 1'b0;
		case (state_q)
			ST_NEGA: begin
				add_sub = 1'b1;
				add_y   = {1'b0, lo_q};
			end
			ST_NEGB: begin
				add_sub = 1'b1;
				add_y   = {1'b0, opnd_q};
			end
			ST_RUN: begin
				if (op_q == OP_MULU) begin
					add_x = {1'b0, acc_q};
					add_y = lo_q[0] ? {1'b0, opnd_q} : '0;
				end else begin
					add_x   = {acc_q, lo_q[WORD_BITS-1]};
					add_y   = {1'b0, opnd_q};
					add_sub = 1'b1;
				end
			end
			ST_FIXQ: begin
				add_sub = 1'b1;
				add_y   = {1'b0, lo_q};
			end
			ST_FIXR: begin
				add_sub = 1'b1;
				add_y   = {1'b0, acc_q};
			end
			default: begin
			end
		endcase
		add_sum = {1'b0, add_x} + {1'b0, add_sub ? ~add_y : add_y}
			+ (WORD_BITS + 2)'(add_sub);
	end

	assign no_borrow = add_sum[WORD_BITS+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			op_q    <= OP_MULU;
			a_neg_q <= 1'b0;
			b_neg_q <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (req.start) begin
						op_q    <= req.op;
						a_neg_q <= (req.op == OP_DIVS) && opa[WORD_BITS-1];
						b_neg_q <= (req.op == OP_DIVS) && opb[WORD_BITS-1];
						count_q <= STEP_LAST;
						state_q <= (req.op == OP_DIVS) ? ST_NEGA : ST_RUN;
					end
				end
				ST_NEGA: state_q <= ST_NEGB;
				ST_NEGB: state_q <= ST_RUN;
				ST_RUN: begin
					if (count_q == '0) begin
						if (op_q == OP_DIVS) begin
							state_q <= ST_FIXQ;
						end else begin
							state_q <= ST_IDLE;
							done_q  <= 1'b1;
						end
					end else begin
						count_q <= count_q - 1'b1;
					end
				end
				ST_FIXQ: state_q <= ST_FIXR;
				ST_FIXR: begin
					state_q <= ST_IDLE;
					done_q  <= 1'b1;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (req.start) begin
					acc_q  <= '0;
					lo_q   <= opa;
					opnd_q <= opb;
				end
			end
			ST_NEGA: begin
				if (a_neg_q) begin
					lo_q <= add_sum[WORD_BITS-1:0];
				end
			end
			ST_NEGB: begin
				if (b_neg_q) begin
					opnd_q <= add_sum[WORD_BITS-1:0];
				end
			end
			ST_RUN: begin
				if (op_q == OP_MULU) begin
					acc_q <= add_sum[WORD_BITS:1];
					lo_q  <= {add_sum[0], lo_q[WORD_BITS-1:1]};
				end else begin
					// restore on borrow: keep the shifted remainder
					acc_q <= no_borrow ? add_sum[WORD_BITS-1:0] : add_x[WORD_BITS-1:0];
					lo_q  <= {lo_q[WORD_BITS-2:0], no_borrow};
				end
			end
			ST_FIXQ: begin
				if (a_neg_q ^ b_neg_q) begin
					lo_q <= add_sum[WORD_BITS-1:0];
				end
			end
			ST_FIXR: begin
				if (a_neg_q) begin
					acc_q <= add_sum[WORD_BITS-1:0];
				end
			end
			default: begin
			end
		endcase
	end

	// hold busy through the done cycle so HI/LO are written before the next beat
	assign rsp.busy = (state_q != ST_IDLE) || done_q;
	assign rsp.done = done_q;
	assign hi       = acc_q;
	assign lo       = lo_q;

endmodule

FILE: hdl/mips_multiply_divide_unit.sv
// HI/LO multiply-divide unit. Each input beat carries a command and two operands
// and yields exactly one output beat: the HI or LO value for the read commands,
// zero for every other command. The output beat is registered and issued in the
// cycle after the input beat is taken. Moves free the input side again unless the
// output beat is stalled; after multiply or divide the next input beat is taken
// once the core is idle and HI/LO are written. The wait is set by the 32 passes of
// the single shared adder (shift-add multiply, restoring divide), the done flag
// and the write of HI/LO, plus two negation steps before and two after a signed divide.
// Divide by zero gives LO all ones (one for a negative signed dividend) and HI the
// dividend.
module mips_multiply_divide_unit import mmdu_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    s_tvalid,
	output logic                    s_tready,
	input  logic [S_TDATA_BITS-1:0] s_tdata,  // command[2:0], operand_a[34:3], operand_b[66:35]
	output logic                    m_tvalid,
	input  logic                    m_tready,
	output logic [M_TDATA_BITS-1:0] m_tdata   // read_value[31:0]
);

	logic [CMD_BITS-1:0]     command;
	logic [DATA_BITS-1:0]    operand_a;
	logic [DATA_BITS-1:0]    operand_b;
	logic                    s_accept;
	logic [WORD_BITS-1:0]    hi_q;
	logic [WORD_BITS-1:0]    lo_q;
	logic                    m_tvalid_q;
	logic [M_TDATA_BITS-1:0] m_tdata_q;
	logic [DATA_BITS-1:0]    read_value;
	core_req_t               core_req;
	core_rsp_t               core_rsp;
	logic [WORD_BITS-1:0]    core_hi;
	logic [WORD_BITS-1:0]    core_lo;

	assign command   = s_tdata[CMD_BITS-1:0];
	assign operand_a = s_tdata[A_LSB +: DATA_BITS];
	assign operand_b = s_tdata[B_LSB +: DATA_BITS];

	assign s_tready = !core_rsp.busy && (!m_tvalid_q || m_tready);
	assign s_accept = s_tvalid && s_tready;

	always_comb begin
		core_req.start = 1'b0;
		core_req.op    = OP_MULU;
		case (command)
			CMD_MULU: begin
				core_req.start = s_accept;
				core_req.op    = OP_MULU;
			end
			CMD_DIVU: begin
				core_req.start = s_accept;
				core_req.op    = OP_DIVU;
			end
			CMD_DIVS: begin
				core_req.start = s_accept;
				core_req.op    = OP_DIVS;
			end
			default: begin
			end
		endcase
	end

	mmdu_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (core_req),
		.opa    (operand_a[WORD_BITS-1:0]),
		.opb    (operand_b[WORD_BITS-1:0]),
		.rsp    (core_rsp),
		.hi     (core_hi),
		.lo     (core_lo)
	);

	always_comb begin
		case (command)
			CMD_RD_HI: read_value = DATA_BITS'(hi_q);
			CMD_RD_LO: read_value = DATA_BITS'(lo_q);
			default:   read_value = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hi_q       <= '0;
			lo_q       <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (core_rsp.done) begin
				hi_q <= core_hi;
				lo_q <= core_lo;
			end else if (s_accept && command == CMD_WR_HI) begin
				hi_q <= operand_a[WORD_BITS-1:0];
			end else if (s_accept && command == CMD_WR_LO) begin
				lo_q <= operand_a[WORD_BITS-1:0];
			end
			if (s_accept) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_accept) begin
			m_tdata_q <= M_TDATA_BITS'(read_value);
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule

FILE: hdl/mmdu_checker.sv
module mmdu_checker import mmdu_pkg::*; (
	input logic                    clk,
	input logic                    arst_n,
	input logic                    s_tvalid,
	input logic                    s_tready,
	input logic [S_TDATA_BITS-1:0] s_tdata,
	input logic                    m_tvalid,
	input logic                    m_tready,
	input logic [M_TDATA_BITS-1:0] m_tdata
);

	logic                s_beat;
	logic [CMD_BITS-1:0] cmd;
	logic [CMD_BITS-1:0] last_cmd_q;

	assign s_beat = s_tvalid && s_tready;
	assign cmd    = s_tdata[CMD_BITS-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_cmd_q <= CMD_MULU;
		end else if (s_beat) begin
			last_cmd_q <= cmd;
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("output beat dropped while stalled");

	a_one_result: assert property (@(posedge clk) disable iff (!arst_n)
		s_beat |=> m_tvalid)
		else $error("no output beat after input beat");

	a_busy_arith: assert property (@(posedge clk) disable iff (!arst_n)
		s_beat && (cmd == CMD_MULU || cmd == CMD_DIVU || cmd == CMD_DIVS) |=> !s_tready)
		else $error("input taken during multiply or divide");

	a_zero_result: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && last_cmd_q != CMD_RD_HI && last_cmd_q != CMD_RD_LO
		|-> m_tdata == '0)
		else $error("non-read command gave a nonzero result");

	a_write_read_hi: assert property (@(posedge clk) disable iff (!arst_n)
		s_beat && cmd == CMD_RD_HI && $past(s_beat && cmd == CMD_WR_HI)
		|=> m_tdata[DATA_BITS-1:0] == $past(s_tdata[A_LSB +: DATA_BITS], 2))
		else $error("read of HI does not return the value just written");

endmodule

bind mips_multiply_divide_unit mmdu_checker u_checker (.*);
